// ----- hdl/dual_ema_level_bar_meter_core_assert.svh -----
// assertion macros for the dual ema level bar meter checker
// expects signals named clk and arst_n in the scope of use
`ifndef DUAL_EMA_LEVEL_BAR_METER_CORE_ASSERT_SVH
`define DUAL_EMA_LEVEL_BAR_METER_CORE_ASSERT_SVH

// same-cycle implication
`define DEMA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dema assertion failed");

// next-cycle implication
`define DEMA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dema assertion failed");

`endif

// ----- hdl/dema_pkg.sv -----
// shared types and constants for the dual ema level bar meter
// no dependencies
package dema_pkg;

	localparam int ACCEL_W = 16;
	localparam int LEVEL_W = 16;
	localparam int PIX_W   = 9;
	localparam int SCALE_W = 13;
	localparam int SUM_W   = 17;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;
	localparam int DIV_STEPS = 16;
	localparam int DIV_CNT_W = 5;

	// register word index, taken from paddr[2]
	localparam logic REG_SCALE  = 1'b0;
	localparam logic REG_PIXELS = 1'b1;

	localparam logic [SCALE_W-1:0] SCALE_RESET  = 13'd80;
	localparam logic [PIX_W-1:0]   PIXELS_RESET = 9'd200;

	// averaging weights
	localparam int FAST_OLD = 9;
	localparam int SLOW_OLD = 98;
	localparam int SLOW_NEW = 2;

	// reciprocal constants: floor(n / d) == (n * recip) >> shift over the used range
	localparam logic [15:0] MEAN_RECIP = 16'd43691;
	localparam int          MEAN_SHIFT = 17;
	localparam logic [18:0] FAST_RECIP = 19'd419431;
	localparam int          FAST_SHIFT = 22;
	localparam logic [22:0] SLOW_RECIP = 23'd5368710;
	localparam int          SLOW_SHIFT = 29;

	typedef struct packed {
		logic load_sum;
		logic load_mean;
		logic load_num;
		logic load_avg;
		logic div_start;
		logic div_lo;
		logic load_hi;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
	} stat_t;

endpackage

// ----- hdl/dema_if.sv -----
// sample and result channel interfaces for the dual ema level bar meter
// depends on dema_pkg
interface dema_sample_if;
	logic valid;
	logic ready;
	logic signed [dema_pkg::ACCEL_W-1:0] accel_x;
	logic signed [dema_pkg::ACCEL_W-1:0] accel_y;
	logic signed [dema_pkg::ACCEL_W-1:0] accel_z;

	modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
	modport sink (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface dema_result_if;
	logic valid;
	logic ready;
	logic [dema_pkg::LEVEL_W-1:0] fast_level;
	logic [dema_pkg::LEVEL_W-1:0] slow_level;
	logic [dema_pkg::PIX_W-1:0]   white_end;
	logic [dema_pkg::PIX_W-1:0]   green_end;
	logic [dema_pkg::PIX_W-1:0]   bar_end;

	modport source (output valid, output fast_level, output slow_level, output white_end,
		output green_end, output bar_end, input ready);
	modport sink (input valid, input fast_level, input slow_level, input white_end,
		input green_end, input bar_end, output ready);
endinterface

// ----- hdl/dema_div.sv -----
// restoring divider, one quotient bit per cycle
// depends on dema_pkg
module dema_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [dema_pkg::LEVEL_W-1:0]   dividend,
	input  logic [dema_pkg::SCALE_W-1:0]   divisor,
	output logic                           busy,
	output logic [dema_pkg::LEVEL_W-1:0]   quot,
	output logic [dema_pkg::SCALE_W-1:0]   rem
);

	logic [dema_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [dema_pkg::LEVEL_W-1:0]   quo_q;
	logic [dema_pkg::SCALE_W-1:0]   rem_q;
	logic [dema_pkg::SCALE_W-1:0]   dvs_q;
	logic [dema_pkg::SCALE_W:0]     trial;
	logic [dema_pkg::SCALE_W:0]     diff;
	logic                           fits;

	assign trial = {rem_q, quo_q[dema_pkg::LEVEL_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= dema_pkg::DIV_CNT_W'(dema_pkg::DIV_STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[dema_pkg::LEVEL_W-2:0], fits};
			rem_q <= fits ? diff[dema_pkg::SCALE_W-1:0] : trial[dema_pkg::SCALE_W-1:0];
		end
	end

	assign busy = cnt_q != '0;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

// ----- hdl/dema_datapath.sv -----
// datapath: axis magnitudes, mean, both averages, bar split and result register
// depends on dema_pkg and dema_div
module dema_datapath #(
	parameter int MAX_PIXELS = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dema_pkg::cmd_t                      cmd,
	output dema_pkg::stat_t                     stat,
	input  logic signed [dema_pkg::ACCEL_W-1:0] accel_x,
	input  logic signed [dema_pkg::ACCEL_W-1:0] accel_y,
	input  logic signed [dema_pkg::ACCEL_W-1:0] accel_z,
	input  logic [dema_pkg::SCALE_W-1:0]        segment_scale,
	input  logic [dema_pkg::PIX_W-1:0]          pixel_count,
	output logic [dema_pkg::LEVEL_W-1:0]        fast_level,
	output logic [dema_pkg::LEVEL_W-1:0]        slow_level,
	output logic [dema_pkg::PIX_W-1:0]          white_end,
	output logic [dema_pkg::PIX_W-1:0]          green_end,
	output logic [dema_pkg::PIX_W-1:0]          bar_end
);

	localparam int LW = dema_pkg::LEVEL_W;
	localparam int PW = dema_pkg::PIX_W;

	function automatic logic [dema_pkg::SUM_W-1:0] mag17(input logic signed [15:0] v);
		logic [dema_pkg::SUM_W-1:0] ext;
		ext = {v[15], v};
		return v[15] ? (dema_pkg::SUM_W'(0) - ext) : ext;
	endfunction

	logic [dema_pkg::SUM_W-1:0] sum_q;
	logic [LW-1:0]              mean_q;
	logic [19:0]                fnum_q;
	logic [21:0]                snum_q;
	logic [LW-1:0]              fast_avg_q;
	logic [LW-1:0]              slow_avg_q;
	logic                       seeded_q;
	logic [LW-1:0]              hi_floor_q;
	logic [LW-1:0]              hi_ceil_q;
	logic [LW-1:0]              fast_lvl_q;
	logic [LW-1:0]              slow_lvl_q;
	logic [PW-1:0]              white_q;
	logic [PW-1:0]              green_q;
	logic [PW-1:0]              bar_q;

	logic [32:0]                mean_prod;
	logic [38:0]                fast_prod;
	logic [44:0]                slow_prod;
	logic [LW-1:0]              hi_lvl;
	logic [LW-1:0]              lo_lvl;
	logic [dema_pkg::SCALE_W-1:0] divisor;
	logic                       div_busy;
	logic [LW-1:0]              div_quot;
	logic [dema_pkg::SCALE_W-1:0] div_rem;
	logic [LW-1:0]              lo_ceil;
	logic [LW-1:0]              slow_ceil;
	logic [PW-1:0]              limit;
	logic [PW-1:0]              bar;
	logic [PW-1:0]              white;
	logic [PW-1:0]              green;

	assign mean_prod = 33'(sum_q) * 33'(dema_pkg::MEAN_RECIP);
	assign fast_prod = 39'(fnum_q) * 39'(dema_pkg::FAST_RECIP);
	assign slow_prod = 45'(snum_q) * 45'(dema_pkg::SLOW_RECIP);

	assign hi_lvl  = (fast_avg_q > slow_avg_q) ? fast_avg_q : slow_avg_q;
	assign lo_lvl  = (fast_avg_q > slow_avg_q) ? slow_avg_q : fast_avg_q;
	assign divisor = (segment_scale == '0) ? dema_pkg::SCALE_W'(1) : segment_scale;

	dema_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (cmd.div_lo ? lo_lvl : hi_lvl),
		.divisor  (divisor),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign stat.div_busy = div_busy;

	always_comb begin
		lo_ceil   = div_quot + LW'(div_rem != '0);
		slow_ceil = (slow_avg_q >= fast_avg_q) ? hi_ceil_q : lo_ceil;
		limit     = (32'(pixel_count) > MAX_PIXELS) ? PW'(MAX_PIXELS) : pixel_count;
		bar       = (hi_floor_q > LW'(limit)) ? limit : hi_floor_q[PW-1:0];
		white     = (lo_ceil > LW'(bar)) ? bar : lo_ceil[PW-1:0];
		green     = (slow_ceil > LW'(bar)) ? bar : slow_ceil[PW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_avg_q <= '0;
			slow_avg_q <= '0;
			seeded_q   <= 1'b0;
		end else if (cmd.load_avg) begin
			seeded_q <= 1'b1;
			if (!seeded_q) begin
				fast_avg_q <= mean_q;
				slow_avg_q <= mean_q;
			end else begin
				fast_avg_q <= fast_prod[dema_pkg::FAST_SHIFT +: LW];
				slow_avg_q <= slow_prod[dema_pkg::SLOW_SHIFT +: LW];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_sum) begin
			sum_q <= mag17(accel_x) + mag17(accel_y) + mag17(accel_z);
		end
		if (cmd.load_mean) begin
			mean_q <= mean_prod[dema_pkg::MEAN_SHIFT +: LW];
		end
		if (cmd.load_num) begin
			fnum_q <= 20'(fast_avg_q) * 20'(dema_pkg::FAST_OLD) + 20'(mean_q);
			snum_q <= 22'(slow_avg_q) * 22'(dema_pkg::SLOW_OLD)
				+ 22'(mean_q) * 22'(dema_pkg::SLOW_NEW);
		end
		if (cmd.load_hi) begin
			hi_floor_q <= div_quot;
			hi_ceil_q  <= div_quot + LW'(div_rem != '0);
		end
		if (cmd.load_out) begin
			fast_lvl_q <= fast_avg_q;
			slow_lvl_q <= slow_avg_q;
			white_q    <= white;
			green_q    <= green;
			bar_q      <= bar;
		end
	end

	assign fast_level = fast_lvl_q;
	assign slow_level = slow_lvl_q;
	assign white_end  = white_q;
	assign green_end  = green_q;
	assign bar_end    = bar_q;

endmodule

// ----- hdl/dema_ctrl.sv -----
// controller: sequences one sample through the datapath and owns result valid
// depends on dema_pkg
module dema_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  dema_pkg::stat_t stat,
	output dema_pkg::cmd_t  cmd
);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_MEAN   = 9'b000000010,
		ST_NUM    = 9'b000000100,
		ST_AVG    = 9'b000001000,
		ST_HI_GO  = 9'b000010000,
		ST_HI_RUN = 9'b000100000,
		ST_LO_GO  = 9'b001000000,
		ST_LO_RUN = 9'b010000000,
		ST_FIN    = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   accept;
	logic   load_out;

	assign in_ready = state_q == ST_IDLE;
	assign accept   = in_valid && in_ready;
	assign load_out = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_nxt = ST_MEAN;
			end
			ST_MEAN:   state_nxt = ST_NUM;
			ST_NUM:    state_nxt = ST_AVG;
			ST_AVG:    state_nxt = ST_HI_GO;
			ST_HI_GO:  state_nxt = ST_HI_RUN;
			ST_HI_RUN: begin
				if (!stat.div_busy) state_nxt = ST_LO_GO;
			end
			ST_LO_GO:  state_nxt = ST_LO_RUN;
			ST_LO_RUN: begin
				if (!stat.div_busy) state_nxt = ST_FIN;
			end
			ST_FIN: begin
				if (load_out) state_nxt = ST_IDLE;
			end
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.load_sum  = accept;
		cmd.load_mean = state_q == ST_MEAN;
		cmd.load_num  = state_q == ST_NUM;
		cmd.load_avg  = state_q == ST_AVG;
		cmd.div_start = (state_q == ST_HI_GO) || (state_q == ST_LO_GO);
		cmd.div_lo    = state_q == ST_LO_GO;
		cmd.load_hi   = state_q == ST_LO_GO;
		cmd.load_out  = load_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- hdl/dual_ema_level_bar_meter_core.sv -----
// one sample in flight: the controller steps mean, num, avg, a hi and a lo pass
// of the shared 16-step restoring divider, then fin, and takes no new sample
// until the result is loaded, which waits while the result side stalls
// reset (arst_n low): controller idle, no result valid, averages unseeded,
// segment_scale back to 80 and pixel_count back to 200
module dual_ema_level_bar_meter_core #(
	parameter int MAX_PIXELS = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	dema_sample_if.sink                     sample,
	dema_result_if.source                   result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dema_pkg::ADDR_W-1:0]     paddr,
	input  logic [dema_pkg::DATA_W-1:0]     pwdata,
	output logic [dema_pkg::DATA_W-1:0]     prdata,
	output logic                            pready
);

	logic [dema_pkg::SCALE_W-1:0] scale_q;
	logic [dema_pkg::PIX_W-1:0]   pixels_q;
	logic                         wr_en;
	dema_pkg::cmd_t               cmd;
	dema_pkg::stat_t              stat;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= dema_pkg::SCALE_RESET;
			pixels_q <= dema_pkg::PIXELS_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				dema_pkg::REG_SCALE:  scale_q  <= pwdata[dema_pkg::SCALE_W-1:0];
				dema_pkg::REG_PIXELS: pixels_q <= pwdata[dema_pkg::PIX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			dema_pkg::REG_SCALE:  prdata = dema_pkg::DATA_W'(scale_q);
			dema_pkg::REG_PIXELS: prdata = dema_pkg::DATA_W'(pixels_q);
			default:              prdata = '0;
		endcase
	end

	dema_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	dema_datapath #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.accel_x       (sample.accel_x),
		.accel_y       (sample.accel_y),
		.accel_z       (sample.accel_z),
		.segment_scale (scale_q),
		.pixel_count   (pixels_q),
		.fast_level    (result.fast_level),
		.slow_level    (result.slow_level),
		.white_end     (result.white_end),
		.green_end     (result.green_end),
		.bar_end       (result.bar_end)
	);

endmodule

// ----- hdl/dema_checker.sv -----
// port-level checker for the dual ema level bar meter, bound to the top level
// depends on dual_ema_level_bar_meter_core_assert.svh
`include "dual_ema_level_bar_meter_core_assert.svh"

module dema_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] fast_level,
	input logic [15:0] slow_level,
	input logic [8:0]  white_end,
	input logic [8:0]  green_end,
	input logic [8:0]  bar_end
);

	`DEMA_ASSERT_IMP(a_bar_order, out_valid, (white_end <= green_end) && (green_end <= bar_end))
	`DEMA_ASSERT_IMP(a_level_range, out_valid, (fast_level <= 16'd32768) && (slow_level <= 16'd32768))
	`DEMA_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)
	`DEMA_ASSERT_NXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(fast_level) && $stable(bar_end))

endmodule

bind dual_ema_level_bar_meter_core dema_checker u_dema_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (sample.valid),
	.in_ready   (sample.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.fast_level (result.fast_level),
	.slow_level (result.slow_level),
	.white_end  (result.white_end),
	.green_end  (result.green_end),
	.bar_end    (result.bar_end)
);
